FILE: rtl/ovn_pkg.sv
// shared types, constants and cosine weight function for the octave value noise unit
package ovn_pkg;

	// defaults for top-level parameters
	localparam int MAX_OCTAVES_DEF    = 16;
	localparam int COS_TABLE_BITS_DEF = 8;

	// configuration register indexes
	localparam logic [2:0] REG_COORD_OFFSET = 3'd0;
	localparam logic [2:0] REG_OCTAVE_COUNT = 3'd1;
	localparam logic [2:0] REG_PERSISTENCE  = 3'd2;
	localparam logic [2:0] REG_BASE_FREQ    = 3'd3;
	localparam logic [2:0] REG_BASE_AMP     = 3'd4;

	// lattice hash constants
	localparam logic [32:0] HASH_ROW_MUL = 33'd57;
	localparam logic [32:0] HASH_SQ_MUL  = 33'd15731;
	localparam logic [31:0] HASH_LIN_ADD = 32'd789221;
	localparam logic [31:0] HASH_FIN_ADD = 32'd1376312589;
	localparam logic [31:0] HASH_MASK    = 32'h7fffffff;

	// noise value of one, Q.16
	localparam logic signed [17:0] NOISE_ONE = 18'sh10000;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT_X,
		ST_INIT_Y,
		ST_OCT,
		ST_HASH_ROW,
		ST_HASH_SQ,
		ST_HASH_LIN,
		ST_HASH_FIN,
		ST_SMOOTH,
		ST_BLEND_X0,
		ST_BLEND_X1,
		ST_BLEND_Y,
		ST_ACCUM,
		ST_AMP,
		ST_DONE
	} ovn_state_t;

	// sin^2 weight of table entry idx in Q0.16, integer series for sine
	function automatic logic [16:0] cos_weight(input int unsigned idx, input int unsigned bits);
		logic [63:0] theta;
		logic [63:0] th2;
		logic [63:0] term;
		logic [63:0] prod;
		logic [63:0] w;
		logic signed [63:0] s;
		theta = (HALF_PI_Q30 * 64'(idx)) >> bits;
		th2   = (theta * theta) >> 30;
		term  = theta;
		s     = $signed(theta);
		for (int k = 1; k <= 6; k++) begin
			prod = (term * th2) >> 30;
			case (k)
				1:       term = prod / 6;
				2:       term = prod / 20;
				3:       term = prod / 42;
				4:       term = prod / 72;
				5:       term = prod / 110;
				default: term = prod / 156;
			endcase
			if ((k % 2) == 1)
				s = s - $signed(term);
			else
				s = s + $signed(term);
		end
		if (s < 0)
			s = 0;
		w = (64'(s) * 64'(s) + (64'd1 << 43)) >> 44;
		if (w > 64'd65536)
			w = 64'd65536;
		return w[16:0];
	endfunction

endpackage

FILE: rtl/ovn_mul.sv
// shared signed 33x33 multiplier used by every multiply step of the sequencer
module ovn_mul (
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p
);
	// one product per cycle, registered by the caller
	assign p = a * b;
endmodule

FILE: rtl/ovn_cos_rom.sv
// constant sin^2 blend weight table indexed by the top fraction bits
module ovn_cos_rom #(
	parameter int COS_TABLE_BITS = ovn_pkg::COS_TABLE_BITS_DEF
) (
	input  logic [COS_TABLE_BITS-1:0] idx,
	output logic [16:0]               w
);
	import ovn_pkg::*;

	localparam int DEPTH = 1 << COS_TABLE_BITS;

	logic [16:0] tab [DEPTH];

	// table entries fixed at elaboration
	for (genvar g = 0; g < DEPTH; g++) begin : g_tab
		assign tab[g] = cos_weight(g, COS_TABLE_BITS);
	end

	assign w = tab[idx];
endmodule

FILE: rtl/octave_value_noise_2d_unit.sv
// fractal 2d value noise: octave sum of smoothed hashed lattice noise with cosine blend
// per octave: 16 lattice hashes of 4 multiplies each, 36 smoothing adds, 5 blend/scale steps
// throughput: one item at a time; all multiplies go through one shared 33x33 multiplier
// reset: registers return to offset 0, 4 octaves, persistence 0.5, frequency 1, amplitude 1
// reset: sequencer idle, no result pending
module octave_value_noise_2d_unit #(
	parameter int MAX_OCTAVES    = ovn_pkg::MAX_OCTAVES_DEF,
	parameter int COS_TABLE_BITS = ovn_pkg::COS_TABLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        point_x,
	input  logic [15:0]        point_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] height
);
	import ovn_pkg::*;

	localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
	localparam int CNT_W   = (OCT_W > 5) ? OCT_W : 5;
	localparam int TOT_RAW = 47 + $clog2(MAX_OCTAVES + 1);
	localparam int TOT_W   = (TOT_RAW > 52) ? TOT_RAW : 52;
	localparam int H_W     = TOT_W - 19;
	localparam int FB      = 16 - COS_TABLE_BITS;

	// configuration registers
	logic signed [15:0] coord_offset_q;
	logic [4:0]         octave_count_q;
	logic [15:0]        persistence_q;
	logic [23:0]        base_freq_q;
	logic [23:0]        base_amp_q;

	// control
	ovn_state_t state_q, state_d;
	logic       out_valid_q;
	logic       in_acc, out_acc;

	// datapath
	logic signed [17:0] px_q, py_q;
	logic [47:0]        prodx_q, prody_q;
	logic [23:0]        amp_q;
	logic [OCT_W-1:0]   oct_q, cnt_q;
	logic [31:0]        ix_q, iy_q;
	logic [16:0]        wx_q, wy_q;
	logic [3:0]         j_q;
	logic [31:0]        n_q, a_q;
	logic signed [17:0] noise_q [16];
	logic [1:0]         c_q, dx_q, dy_q;
	logic signed [21:0] acc_q;
	logic signed [21:0] sm_q [4];
	logic signed [21:0] bl0_q, bl1_q, bl_q;
	logic signed [TOT_W-1:0] total_q;
	logic signed [31:0] height_q;

	// combinational
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [47:0]        cx, cy;
	logic [16:0]        wx_rom, wy_rom;
	logic [31:0]        gx, gy, n0;
	logic [31:0]        hash_t;
	logic signed [17:0] noise_new;
	logic [1:0]         row, col;
	logic signed [21:0] nb_ext, acc_next;
	logic signed [21:0] blend_off;
	logic [CNT_W-1:0]   cnt_lim;
	logic signed [H_W-1:0] h_wide;
	logic signed [31:0] h_sat;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign height    = height_q;

	// shared multiplier
	ovn_mul u_mul (
		.a(mul_a),
		.b(mul_b),
		.p(mul_p)
	);

	// octave coordinates: frequency doubling is a left shift of the base product
	assign cx = prodx_q << oct_q;
	assign cy = prody_q << oct_q;

	ovn_cos_rom #(.COS_TABLE_BITS(COS_TABLE_BITS)) u_rom_x (
		.idx(cx[15:FB]),
		.w  (wx_rom)
	);

	ovn_cos_rom #(.COS_TABLE_BITS(COS_TABLE_BITS)) u_rom_y (
		.idx(cy[15:FB]),
		.w  (wy_rom)
	);

	// lattice point of the 4x4 neighbourhood being hashed
	assign gx = ix_q + 32'(j_q[1:0]) - 32'd1;
	assign gy = iy_q + 32'(j_q[3:2]) - 32'd1;
	assign n0 = gx + mul_p[31:0];

	assign hash_t    = (mul_p[31:0] + HASH_FIN_ADD) & HASH_MASK;
	assign noise_new = NOISE_ONE - $signed({1'b0, hash_t[30:14]});

	// smoothing tap: corners weight 1, sides 2, center 4
	assign row = c_q[1] + dy_q;
	assign col = c_q[0] + dx_q;
	always_comb begin
		nb_ext = 22'(noise_q[{row, col}]);
		if (dx_q == 2'd1 && dy_q == 2'd1)
			acc_next = acc_q + (nb_ext <<< 2);
		else if (dx_q == 2'd1 || dy_q == 2'd1)
			acc_next = acc_q + (nb_ext <<< 1);
		else
			acc_next = acc_q + nb_ext;
	end

	// floor of diff * w / 65536, kept mod 2^22 since the blend stays in range
	assign blend_off = mul_p[37:16];

	assign cnt_lim = (CNT_W'(octave_count_q) > CNT_W'(MAX_OCTAVES)) ?
		CNT_W'(MAX_OCTAVES) : CNT_W'(octave_count_q);

	// final scale and saturation
	assign h_wide = total_q[TOT_W-1:19];
	always_comb begin
		if (h_wide > $signed(H_W'(32'sh7fffffff)))
			h_sat = 32'sh7fffffff;
		else if (h_wide < $signed(H_W'(-33'sh80000000)))
			h_sat = 32'sh80000000;
		else
			h_sat = h_wide[31:0];
	end

	// next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc)
					state_d = ST_INIT_X;
			end
			ST_INIT_X: begin
				mul_a   = 33'(px_q);
				mul_b   = {9'd0, base_freq_q};
				state_d = ST_INIT_Y;
			end
			ST_INIT_Y: begin
				mul_a   = 33'(py_q);
				mul_b   = {9'd0, base_freq_q};
				state_d = ST_OCT;
			end
			ST_OCT: begin
				state_d = (oct_q == cnt_q) ? ST_DONE : ST_HASH_ROW;
			end
			ST_HASH_ROW: begin
				mul_a   = {1'b0, gy};
				mul_b   = HASH_ROW_MUL;
				state_d = ST_HASH_SQ;
			end
			ST_HASH_SQ: begin
				mul_a   = {1'b0, n_q};
				mul_b   = {1'b0, n_q};
				state_d = ST_HASH_LIN;
			end
			ST_HASH_LIN: begin
				mul_a   = {1'b0, a_q};
				mul_b   = HASH_SQ_MUL;
				state_d = ST_HASH_FIN;
			end
			ST_HASH_FIN: begin
				mul_a   = {1'b0, n_q};
				mul_b   = {1'b0, a_q};
				state_d = (j_q == 4'd15) ? ST_SMOOTH : ST_HASH_ROW;
			end
			ST_SMOOTH: begin
				if (dx_q == 2'd2 && dy_q == 2'd2 && c_q == 2'd3)
					state_d = ST_BLEND_X0;
			end
			ST_BLEND_X0: begin
				mul_a   = 33'(sm_q[1]) - 33'(sm_q[0]);
				mul_b   = {16'd0, wx_q};
				state_d = ST_BLEND_X1;
			end
			ST_BLEND_X1: begin
				mul_a   = 33'(sm_q[3]) - 33'(sm_q[2]);
				mul_b   = {16'd0, wx_q};
				state_d = ST_BLEND_Y;
			end
			ST_BLEND_Y: begin
				mul_a   = 33'(bl1_q) - 33'(bl0_q);
				mul_b   = {16'd0, wy_q};
				state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				mul_a   = 33'(bl_q);
				mul_b   = {9'd0, amp_q};
				state_d = ST_AMP;
			end
			ST_AMP: begin
				mul_a   = {9'd0, amp_q};
				mul_b   = {17'd0, persistence_q};
				state_d = ST_OCT;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_acc)
				out_valid_q <= 1'b0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_offset_q <= '0;
			octave_count_q <= 5'd4;
			persistence_q  <= 16'd32768;
			base_freq_q    <= 24'd65536;
			base_amp_q     <= 24'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COORD_OFFSET: coord_offset_q <= $signed(cfg_data[15:0]);
				REG_OCTAVE_COUNT: octave_count_q <= cfg_data[4:0];
				REG_PERSISTENCE:  persistence_q  <= cfg_data[15:0];
				REG_BASE_FREQ:    base_freq_q    <= cfg_data;
				REG_BASE_AMP:     base_amp_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					px_q    <= $signed({2'b0, point_x}) + 18'(coord_offset_q);
					py_q    <= $signed({2'b0, point_y}) + 18'(coord_offset_q);
					amp_q   <= base_amp_q;
					oct_q   <= '0;
					cnt_q   <= OCT_W'(cnt_lim);
					total_q <= '0;
				end
			end
			ST_INIT_X: prodx_q <= mul_p[47:0];
			ST_INIT_Y: prody_q <= mul_p[47:0];
			ST_OCT: begin
				ix_q <= cx[47:16];
				iy_q <= cy[47:16];
				wx_q <= wx_rom;
				wy_q <= wy_rom;
				j_q  <= '0;
			end
			ST_HASH_ROW: n_q <= (n0 << 13) ^ n0;
			ST_HASH_SQ:  a_q <= mul_p[31:0];
			ST_HASH_LIN: a_q <= mul_p[31:0] + HASH_LIN_ADD;
			ST_HASH_FIN: begin
				noise_q[j_q] <= noise_new;
				j_q          <= j_q + 4'd1;
				c_q          <= '0;
				dx_q         <= '0;
				dy_q         <= '0;
				acc_q        <= '0;
			end
			ST_SMOOTH: begin
				if (dx_q == 2'd2) begin
					dx_q <= '0;
					if (dy_q == 2'd2) begin
						dy_q     <= '0;
						sm_q[c_q] <= acc_next;
						acc_q    <= '0;
						c_q      <= c_q + 2'd1;
					end else begin
						dy_q  <= dy_q + 2'd1;
						acc_q <= acc_next;
					end
				end else begin
					dx_q  <= dx_q + 2'd1;
					acc_q <= acc_next;
				end
			end
			ST_BLEND_X0: bl0_q <= sm_q[0] + blend_off;
			ST_BLEND_X1: bl1_q <= sm_q[2] + blend_off;
			ST_BLEND_Y:  bl_q  <= bl0_q + blend_off;
			ST_ACCUM:    total_q <= total_q + mul_p[TOT_W-1:0];
			ST_AMP: begin
				amp_q <= mul_p[39:16];
				oct_q <= oct_q + OCT_W'(1);
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall)
					height_q <= h_sat;
			end
			default: ;
		endcase
	end

endmodule

FILE: sim/tb_top.sv
// testbench for the octave value noise unit: config phases, directed and random points, scoreboard
module tb_top;
	import ovn_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd5;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 2000;

	// expected heights, worked out from the configured registers
	class noise_scoreboard;
		int signed offset;
		int unsigned octaves;
		int unsigned persist;
		int unsigned freq0;
		int unsigned amp0;
		logic signed [31:0] expected_heights[$];
		longint unsigned weight_lut[256];

		function new();
			for (int i = 0; i < 256; i++)
				weight_lut[i] = sine_sq_weight(i);
			offset = 0;
			octaves = 4;
			persist = 32768;
			freq0 = 65536;
			amp0 = 65536;
		endfunction

		// sin^2 via truncated taylor series in Q30, squared down to Q0.16
		function longint unsigned sine_sq_weight(int unsigned idx);
			longint unsigned theta, th2, term, w;
			longint signed s;
			theta = (64'd1686629713 * 64'(idx)) >> 8;
			th2 = (theta * theta) >> 30;
			term = theta;
			s = $signed(theta);
			for (int k = 1; k <= 6; k++) begin
				term = ((term * th2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1)
					s = s - $signed(term);
				else
					s = s + $signed(term);
			end
			if (s < 0)
				s = 0;
			w = (64'(s) * 64'(s) + (64'd1 << 43)) >> 44;
			if (w > 65536)
				w = 65536;
			return w;
		endfunction

		function void set_reg(logic [2:0] idx, logic [23:0] v);
			case (idx)
				REG_COORD_OFFSET: offset = $signed(v[15:0]);
				REG_OCTAVE_COUNT: octaves = v[4:0];
				REG_PERSISTENCE:  persist = v[15:0];
				REG_BASE_FREQ:    freq0 = v;
				REG_BASE_AMP:     amp0 = v;
				default: ;
			endcase
		endfunction

		// integer lattice hash into Q.16 noise
		function longint signed hash_noise(logic [31:0] x, logic [31:0] y);
			logic [31:0] n, t;
			n = x + y * 32'd57;
			n = (n << 13) ^ n;
			t = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
			return 65536 - longint'(t >> 14);
		endfunction

		// 3x3 smoothing kept in Q.20
		function longint signed smooth_sum(logic [31:0] x, logic [31:0] y);
			longint signed c, sd;
			c = hash_noise(x - 1, y - 1) + hash_noise(x + 1, y - 1)
				+ hash_noise(x - 1, y + 1) + hash_noise(x + 1, y + 1);
			sd = hash_noise(x - 1, y) + hash_noise(x + 1, y)
				+ hash_noise(x, y - 1) + hash_noise(x, y + 1);
			return c + 2 * sd + 4 * hash_noise(x, y);
		endfunction

		function longint signed mix(longint signed a, longint signed b, longint unsigned w);
			return (a * (65536 - longint'(w)) + b * longint'(w)) >>> 16;
		endfunction

		function void note_point(logic [15:0] x, logic [15:0] y);
			longint signed px, py, total, h, v1, v2, v3, v4;
			longint unsigned cx, cy, freq, amp, wx, wy;
			logic [31:0] ix, iy;
			int unsigned count;
			px = longint'(x) + offset;
			py = longint'(y) + offset;
			freq = freq0;
			amp = amp0;
			count = octaves > 16 ? 16 : octaves;
			total = 0;
			for (int i = 0; i < count; i++) begin
				cx = px * freq;
				cy = py * freq;
				ix = cx[47:16];
				iy = cy[47:16];
				wx = weight_lut[cx[15:8]];
				wy = weight_lut[cy[15:8]];
				v1 = smooth_sum(ix, iy);
				v2 = smooth_sum(ix + 1, iy);
				v3 = smooth_sum(ix, iy + 1);
				v4 = smooth_sum(ix + 1, iy + 1);
				total += mix(mix(v1, v2, wx), mix(v3, v4, wx), wy) * longint'(amp);
				amp = (amp * persist) >> 16;
				freq = freq << 1;
			end
			h = total >>> 19;
			if (h > 64'sd2147483647)
				h = 64'sd2147483647;
			if (h < -64'sd2147483648)
				h = -64'sd2147483648;
			expected_heights.push_back(h[31:0]);
		endfunction

		// 0 match, 1 mismatch, 2 nothing expected
		function int check_height(logic signed [31:0] h, output logic signed [31:0] want);
			want = 0;
			if (expected_heights.size() == 0)
				return 2;
			want = expected_heights.pop_front();
			return (want == h) ? 0 : 1;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [15:0] point_x;
	logic [15:0] point_y;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] height;

	noise_scoreboard sb;
	int errors;
	bit idle_en;
	bit hold_req;

	octave_value_noise_2d_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.point_x(point_x),
		.point_y(point_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.height(height)
	);

	// clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] v);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = v;
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic write_all(logic [23:0] off, logic [23:0] oct, logic [23:0] pers,
		logic [23:0] freq, logic [23:0] amp);
		write_reg(REG_COORD_OFFSET, off);
		write_reg(REG_OCTAVE_COUNT, oct);
		write_reg(REG_PERSISTENCE, pers);
		write_reg(REG_BASE_FREQ, freq);
		write_reg(REG_BASE_AMP, amp);
	endtask

	// offer one item, with an optional idle burst before it
	task automatic send_point(logic [15:0] x, logic [15:0] y);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid = 1;
		point_x = x;
		point_y = y;
		do @(posedge clk); while (in_stall);
		sb.note_point(x, y);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic drain();
		while (sb.expected_heights.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_points(int count);
		for (int i = 0; i < count; i++)
			send_point(16'($urandom), 16'($urandom));
	endtask

	// receiver stall bursts and the long hold-off
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall = 1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall = 0;
			end else if (idle_en && $urandom_range(0, 6) == 0) begin
				out_stall = 1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				out_stall = 0;
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		logic signed [31:0] want;
		int verdict;
		if (arst_n && out_valid && !out_stall) begin
			verdict = sb.check_height(height, want);
			if (verdict == 2)
				report("unexpected height", height, 0);
			else if (verdict == 1)
				report("height", height, want);
		end
	end

	// run limit
	initial begin
		#40000000;
		$display("CHECK FAILED");
		$finish;
	end

	// main sequence
	initial begin
		sb = new();
		errors = 0;
		idle_en = 1;
		hold_req = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_COORD_OFFSET;
		cfg_data = 0;
		in_valid = 0;
		point_x = 0;
		point_y = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset settings, field extremes
		send_point(16'h0000, 16'h0000);
		send_point(16'hffff, 16'hffff);
		send_point(16'h0000, 16'hffff);
		send_point(16'hffff, 16'h0000);
		send_point(16'haaaa, 16'h5555);
		drain();

		// most negative offset, max scale, one octave; long receiver hold-off
		write_all(24'h008000, 24'd1, 24'd65535, 24'hffffff, 24'hffffff);
		hold_req = 1;
		send_point(16'h0000, 16'h0000);
		send_point(16'h7fff, 16'h8000);
		send_point(16'hffff, 16'h0001);
		send_point(16'h1234, 16'hfedc);
		drain();

		// zero octaves, zero scales, max offset; unused register index ignored
		write_all(24'h007fff, 24'd0, 24'd0, 24'd0, 24'd0);
		write_reg(REG_UNUSED, 24'hffffff);
		send_point(16'hffff, 16'hffff);
		send_point(16'h0000, 16'h0000);
		drain();

		// octave count above the limit, huge coordinates, negative offset
		write_all(24'hffffff, 24'd17, 24'd65535, 24'hffffff, 24'h010000);
		send_point(16'h0000, 16'h0000);
		send_point(16'hffff, 16'hffff);
		drain();
		write_all(24'h00ffff, 24'd31, 24'd40000, 24'h018000, 24'h0000ff);
		send_point(16'h0001, 16'h0000);
		send_point(16'h8000, 16'h7fff);
		drain();
		write_all(24'h000000, 24'd16, 24'd0, 24'h000001, 24'hffffff);
		send_point(16'hffff, 16'h0000);
		drain();

		// random phases, mostly few octaves
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 9)
				idle_en = 0;
			write_all(24'($urandom), (ph == 4) ? 24'd16 : 24'($urandom_range(0, 5)),
				24'($urandom),
				($urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 24'h40000))),
				24'($urandom));
			random_points(62);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/ovn_pkg.sv
rtl/ovn_mul.sv
rtl/ovn_cos_rom.sv
rtl/octave_value_noise_2d_unit.sv
sim/tb_top.sv
